/* design/fbwc_pkg.sv */
// fbwc_pkg: word types, character codes and the hex digit table
// shared by the frame builder top level and its checker
`default_nettype none

package fbwc_pkg;

  localparam logic [9:0] CK_MOD = 10'd999;

  localparam logic [7:0] START_CHAR = 8'h5E;  // '^'
  localparam logic [7:0] SEP_CHAR   = 8'h7C;  // '|'
  localparam logic [7:0] END_CHAR   = 8'h24;  // '$'

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       empty_frame;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_word_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    hex_char = HEX_CHARS[nib];
  endfunction

endpackage

`default_nettype wire

/* design/frame_builder_weighted_checksum_unit.sv */
// frame_builder_weighted_checksum_unit: wraps payload words into '^' body '|' sum '$' frames
// with a position weighted checksum modulo 999; uses fbwc_pkg
//
//   channel | direction | handshake           | word
//   in      | in        | in_valid / in_stall   | fbwc_pkg::in_word_t
//   out     | out       | out_valid / out_stall | fbwc_pkg::out_word_t
//
// one output word per cycle while out is not stalled; a payload word that is not first or last
// yields its byte, the first is preceded by '^', the last is followed by '|', one to three digits and '$'
// all characters pass through the single output register, which takes one character a cycle when not stalled
// rst clears the frame state, the pending item and the output valid flag
// a stall on out holds the output word and stalls in while an item is pending
`default_nettype none

module frame_builder_weighted_checksum_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire fbwc_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fbwc_pkg::out_word_t      out_data
);

  typedef enum logic [6:0] {
    PH_HEAD = 7'b0000001,
    PH_BODY = 7'b0000010,
    PH_SEP  = 7'b0000100,
    PH_D2   = 7'b0001000,
    PH_D1   = 7'b0010000,
    PH_D0   = 7'b0100000,
    PH_END  = 7'b1000000
  } ph_t;

  logic                in_frame;
  logic [9:0]          pos;
  logic [9:0]          sum;
  logic                acc;
  logic                cur_valid;
  fbwc_pkg::in_word_t  cur;
  logic [17:0]         prod;
  ph_t                 ph;

  ph_t                 ph_next;
  ph_t                 ph_start;
  logic                out_free;
  logic                emit;
  logic                last_char;
  logic                done;
  logic                accept;
  fbwc_pkg::out_word_t char_next;
  logic [9:0]          pos_base;
  logic [9:0]          pos_inc;
  logic [12:0]         fold1;
  logic [10:0]         fold2;
  logic [9:0]          prod_res;
  logic [10:0]         sum_add;
  logic [9:0]          sum_next;

  assign out_free  = !out_valid || !out_stall;
  assign emit      = cur_valid && out_free;
  assign last_char = (ph == PH_END) || ((ph == PH_BODY) && !cur.last_byte);
  assign done      = emit && last_char;
  assign in_stall  = cur_valid && !done;
  assign accept    = in_valid && !in_stall;

  // position of this word, and product residue by folding 1024 = 25 mod 999
  assign pos_base = in_frame ? pos : 10'd0;
  assign pos_inc  = (pos_base == fbwc_pkg::CK_MOD - 10'd1) ? 10'd0 : pos_base + 10'd1;
  assign fold1    = 13'(prod[17:10]) * 13'd25 + 13'(prod[9:0]);
  assign fold2    = 11'(fold1[12:10]) * 11'd25 + 11'(fold1[9:0]);
  assign prod_res = (fold2 >= 11'(fbwc_pkg::CK_MOD)) ?
                    10'(fold2 - 11'(fbwc_pkg::CK_MOD)) : fold2[9:0];
  assign sum_add  = 11'(sum) + 11'(prod_res);
  assign sum_next = (sum_add >= 11'(fbwc_pkg::CK_MOD)) ?
                    10'(sum_add - 11'(fbwc_pkg::CK_MOD)) : sum_add[9:0];

  always_comb begin
    if (in_data.empty_frame) begin
      ph_start = in_frame ? PH_SEP : PH_HEAD;
    end else begin
      ph_start = in_frame ? PH_BODY : PH_HEAD;
    end
  end

  always_comb begin
    char_next = '{out_byte: fbwc_pkg::START_CHAR, frame_end: 1'b0};
    ph_next   = ph;
    unique case (ph)
      PH_HEAD: begin
        ph_next = cur.empty_frame ? PH_SEP : PH_BODY;
      end
      PH_BODY: begin
        char_next.out_byte = cur.payload_byte;
        ph_next = PH_SEP;
      end
      PH_SEP: begin
        char_next.out_byte = fbwc_pkg::SEP_CHAR;
        if (sum[9:8] != 2'd0) begin
          ph_next = PH_D2;
        end else if (sum[7:4] != 4'd0) begin
          ph_next = PH_D1;
        end else begin
          ph_next = PH_D0;
        end
      end
      PH_D2: begin
        char_next.out_byte = fbwc_pkg::hex_char({2'b00, sum[9:8]});
        ph_next = PH_D1;
      end
      PH_D1: begin
        char_next.out_byte = fbwc_pkg::hex_char(sum[7:4]);
        ph_next = PH_D0;
      end
      PH_D0: begin
        char_next.out_byte = fbwc_pkg::hex_char(sum[3:0]);
        ph_next = PH_END;
      end
      PH_END: begin
        char_next = '{out_byte: fbwc_pkg::END_CHAR, frame_end: 1'b1};
      end
      default: begin
        ph_next = PH_END;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      pos       <= 10'd0;
      sum       <= 10'd0;
      acc       <= 1'b0;
      cur_valid <= 1'b0;
      ph        <= PH_HEAD;
      out_valid <= 1'b0;
    end else begin
      acc <= accept;
      if (acc) begin
        sum <= sum_next;
      end else if (emit && (ph == PH_END)) begin
        sum <= 10'd0;
      end

      if (accept) begin
        cur_valid <= 1'b1;
        ph        <= ph_start;
        if (in_data.empty_frame || in_data.last_byte) begin
          in_frame <= 1'b0;
          pos      <= 10'd0;
        end else begin
          in_frame <= 1'b1;
          pos      <= pos_inc;
        end
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        ph <= ph_next;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, product and output data registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= in_data;
      prod <= in_data.empty_frame ? 18'd0 : 18'(pos_base) * 18'(in_data.payload_byte);
    end
    if (emit) begin
      out_data <= char_next;
    end
  end

endmodule

`default_nettype wire

/* design/fbwc_checker.sv */
// fbwc_checker: port level assertions for the frame builder top level
// uses fbwc_pkg; bound to frame_builder_weighted_checksum_unit
`default_nettype none

module fbwc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire fbwc_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire fbwc_pkg::out_word_t out_data
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_end_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.out_byte == fbwc_pkg::END_CHAR)
    else $error("frame end on a character other than the end mark");

  // an accepted input word shows up on the output after passing the item and output registers
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> ##1 out_valid)
    else $error("accepted word produced no output");

endmodule

bind frame_builder_weighted_checksum_unit fbwc_checker u_fbwc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
